/* src/assert_macros.svh */
// assertion helpers for the glyph cache checker
// both macros sample on clk and are disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define GCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define GCF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/gcf_pkg.sv */
`default_nettype none
package gcf_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int CODE_W = 16;
  localparam int SLOT_W = 8;
  localparam int X_W = 10;
  localparam int Y_W = 9;
  localparam int BYTES_W = 64;
  localparam int PIX_W = 64;
  localparam int CFG_W = 10;
  localparam int CFG_IDX_W = 1;

  localparam int LOADS = 4;
  localparam int LOAD_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y = CFG_IDX_W'(1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [LOAD_W-1:0] LAST_LOAD = LOAD_W'(LOADS - 1);

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [3:0][PIX_W-1:0] pix4_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_EMIT
  } gcf_state_t;

  // control from the sequencer to the ring of code cells
  typedef struct packed {
    logic  shift;
    logic  wr_en;
    idx_t  wr_idx;
    code_t wr_code;
  } ring_ctl_t;

endpackage
`default_nettype wire

/* src/gcf_cell.sv */
`default_nettype none
module gcf_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift_en,
  input  logic                 wr_en,
  input  gcf_pkg::code_t       shift_in,
  input  gcf_pkg::code_t       wr_code,
  output gcf_pkg::code_t       code
);
  import gcf_pkg::*;

  code_t code_r;
  code_t code_nxt;

  always_comb begin
    code_nxt = code_r;
    priority if (wr_en) begin
      code_nxt = wr_code;
    end else if (shift_en) begin
      code_nxt = shift_in;
    end else begin
      code_nxt = code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
    end else begin
      code_r <= code_nxt;
    end
  end

  assign code = code_r;

endmodule
`default_nettype wire

/* src/gcf_ring.sv */
`default_nettype none
module gcf_ring (
  input  logic               clk,
  input  logic               rst_n,
  input  gcf_pkg::ring_ctl_t ctl,
  output gcf_pkg::code_t     head_code
);
  import gcf_pkg::*;

  code_t codes [TABLE_ENTRIES];

  // cell i takes the code of cell i+1, so slot s reaches the head after s shifts
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    gcf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (ctl.shift),
      .wr_en    (ctl.wr_en && (ctl.wr_idx == IDX_W'(i))),
      .shift_in (codes[(i + 1) % TABLE_ENTRIES]),
      .wr_code  (ctl.wr_code),
      .code     (codes[i])
    );
  end

  assign head_code = codes[0];

endmodule
`default_nettype wire

/* src/gcf_expand.sv */
`default_nettype none
module gcf_expand (
  input  logic [gcf_pkg::BYTES_W-1:0] src,
  output gcf_pkg::pix4_t              px
);
  import gcf_pkg::*;

  // msb of the byte lands in the lowest nibble, each pixel is 0 or 1
  function automatic logic [31:0] expand_byte(input logic [7:0] b);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 8; j++) begin
      w[j*4] = b[7-j];
    end
    return w;
  endfunction

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      px[m] = {expand_byte(src[16*m+8 +: 8]), expand_byte(src[16*m +: 8])};
    end
  end

endmodule
`default_nettype wire

/* src/glyph_cache_fifo_with_bit_expand_core.sv */
`default_nettype none
// glyph tile cache: a request carries a 16-bit character code and its 1bpp glyph
// bytes. the codes live in a ring of 256 cells that rotates one position per
// cycle past a single comparator at the head, so a lookup always takes one full
// turn and leaves every code back in its own cell; the first match seen gives
// the lowest matching slot. a hit returns one result with the slot. a miss
// writes the code into the cell under the round-robin replace pointer, advances
// the pointer and returns either one result (no glyph data) or four image loads
// for the slot's 16x16 tile, each with the rectangle origin and eight 4bpp words
// expanded from eight glyph bytes. one request is worked at a time: accept,
// one full ring turn of search, decide, then the results, which wait while the
// output side stalls. the output register lets the next request be accepted
// while the final result still waits. all cells clear together at reset, no
// clearing pass is needed. base_x / base_y must be written by the user only
// while the block is idle; the block itself does not enforce it.
module glyph_cache_fifo_with_bit_expand_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gcf_pkg::CODE_W-1:0]    in_char_code,
  input  logic                          in_glyph_present,
  input  logic [gcf_pkg::BYTES_W-1:0]   in_glyph_bytes_a,
  input  logic [gcf_pkg::BYTES_W-1:0]   in_glyph_bytes_b,
  input  logic [gcf_pkg::BYTES_W-1:0]   in_glyph_bytes_c,
  input  logic [gcf_pkg::BYTES_W-1:0]   in_glyph_bytes_d,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gcf_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_hit,
  output logic                          out_load_valid,
  output logic [gcf_pkg::X_W-1:0]       out_rect_x,
  output logic [gcf_pkg::Y_W-1:0]       out_rect_y,
  output logic [gcf_pkg::PIX_W-1:0]     out_pixels_01,
  output logic [gcf_pkg::PIX_W-1:0]     out_pixels_23,
  output logic [gcf_pkg::PIX_W-1:0]     out_pixels_45,
  output logic [gcf_pkg::PIX_W-1:0]     out_pixels_67,
  output logic                          out_last,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [gcf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gcf_pkg::CFG_W-1:0]     cfg_data
);
  import gcf_pkg::*;

  // sequencer state
  gcf_state_t state_r, state_nxt;
  idx_t       cnt_r, cnt_nxt;         // slot currently at the ring head
  logic       found_r, found_nxt;
  idx_t       fslot_r, fslot_nxt;     // first matching slot
  idx_t       ptr_r, ptr_nxt;         // replace pointer

  // captured request
  code_t                    key_r, key_nxt;
  logic                     present_r, present_nxt;
  logic [3:0][BYTES_W-1:0]  bytes_r, bytes_nxt;

  // decided outcome
  idx_t              res_slot_r, res_slot_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic              res_load_r, res_load_nxt;
  logic [LOAD_W-1:0] k_r, k_nxt;

  // configuration
  logic [X_W-1:0] base_x_r, base_x_nxt;
  logic [Y_W-1:0] base_y_r, base_y_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic [SLOT_W-1:0] o_slot_r, o_slot_nxt;
  logic              o_hit_r, o_hit_nxt;
  logic              o_load_r, o_load_nxt;
  logic [X_W-1:0]    o_rx_r, o_rx_nxt;
  logic [Y_W-1:0]    o_ry_r, o_ry_nxt;
  pix4_t             o_px_r, o_px_nxt;
  logic              o_last_r, o_last_nxt;

  ring_ctl_t   ring_ctl;
  code_t       head_code;
  pix4_t       exp_px;
  logic [SLOT_W-1:0] slot_ext;
  logic        emit_last;

  gcf_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ring_ctl),
    .head_code (head_code)
  );

  // expand the eight glyph bytes that belong to the current load
  gcf_expand u_expand (
    .src (bytes_r[k_r]),
    .px  (exp_px)
  );

  assign slot_ext  = SLOT_W'(res_slot_r);
  assign emit_last = !res_load_r || (k_r == LAST_LOAD);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    found_nxt    = found_r;
    fslot_nxt    = fslot_r;
    ptr_nxt      = ptr_r;
    key_nxt      = key_r;
    present_nxt  = present_r;
    bytes_nxt    = bytes_r;
    res_slot_nxt = res_slot_r;
    res_hit_nxt  = res_hit_r;
    res_load_nxt = res_load_r;
    k_nxt        = k_r;
    base_x_nxt   = base_x_r;
    base_y_nxt   = base_y_r;

    ov_nxt     = ov_r;
    o_slot_nxt = o_slot_r;
    o_hit_nxt  = o_hit_r;
    o_load_nxt = o_load_r;
    o_rx_nxt   = o_rx_r;
    o_ry_nxt   = o_ry_r;
    o_px_nxt   = o_px_r;
    o_last_nxt = o_last_r;

    ring_ctl = '0;
    in_stall = (state_r != ST_IDLE);

    // result taken downstream
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      unique case (cfg_idx)
        CFG_BASE_X: base_x_nxt = cfg_data[X_W-1:0];
        CFG_BASE_Y: base_y_nxt = cfg_data[Y_W-1:0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt     = in_char_code;
          present_nxt = in_glyph_present;
          bytes_nxt   = {in_glyph_bytes_d, in_glyph_bytes_c,
                         in_glyph_bytes_b, in_glyph_bytes_a};
          cnt_nxt     = '0;
          found_nxt   = 1'b0;
          state_nxt   = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        // one slot per cycle passes the head comparator
        ring_ctl.shift = 1'b1;
        if (!found_r && (head_code == key_r)) begin
          found_nxt = 1'b1;
          fslot_nxt = cnt_r;
        end
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_DECIDE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_DECIDE: begin
        k_nxt = '0;
        if (found_r) begin
          res_slot_nxt = fslot_r;
          res_hit_nxt  = 1'b1;
          res_load_nxt = 1'b0;
        end else begin
          // fifo replacement: claim the slot under the pointer
          ring_ctl.wr_en   = 1'b1;
          ring_ctl.wr_idx  = ptr_r;
          ring_ctl.wr_code = key_r;
          res_slot_nxt     = ptr_r;
          res_hit_nxt      = 1'b0;
          res_load_nxt     = present_r;
          ptr_nxt          = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
        end
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt     = 1'b1;
          o_slot_nxt = slot_ext;
          o_hit_nxt  = res_hit_r;
          o_load_nxt = res_load_r;
          o_last_nxt = emit_last;
          if (res_load_r) begin
            o_rx_nxt = base_x_r + X_W'({slot_ext[3:0], 2'b00});
            o_ry_nxt = base_y_r + Y_W'({slot_ext[7:4], 4'b0000})
                       + Y_W'({k_r, 2'b00});
            o_px_nxt = exp_px;
          end else begin
            o_rx_nxt = '0;
            o_ry_nxt = '0;
            o_px_nxt = '0;
          end
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      found_r  <= 1'b0;
      ptr_r    <= '0;
      k_r      <= '0;
      base_x_r <= '0;
      base_y_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      found_r  <= found_nxt;
      ptr_r    <= ptr_nxt;
      k_r      <= k_nxt;
      base_x_r <= base_x_nxt;
      base_y_r <= base_y_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fslot_r    <= fslot_nxt;
    key_r      <= key_nxt;
    present_r  <= present_nxt;
    bytes_r    <= bytes_nxt;
    res_slot_r <= res_slot_nxt;
    res_hit_r  <= res_hit_nxt;
    res_load_r <= res_load_nxt;
    o_slot_r   <= o_slot_nxt;
    o_hit_r    <= o_hit_nxt;
    o_load_r   <= o_load_nxt;
    o_rx_r     <= o_rx_nxt;
    o_ry_r     <= o_ry_nxt;
    o_px_r     <= o_px_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid      = ov_r;
  assign out_slot       = o_slot_r;
  assign out_hit        = o_hit_r;
  assign out_load_valid = o_load_r;
  assign out_rect_x     = o_rx_r;
  assign out_rect_y     = o_ry_r;
  assign out_pixels_01  = o_px_r[0];
  assign out_pixels_23  = o_px_r[1];
  assign out_pixels_45  = o_px_r[2];
  assign out_pixels_67  = o_px_r[3];
  assign out_last       = o_last_r;

endmodule
`default_nettype wire

/* src/gcf_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module gcf_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [gcf_pkg::SLOT_W-1:0]    out_slot,
  input  logic                          out_hit,
  input  logic                          out_load_valid,
  input  logic [gcf_pkg::X_W-1:0]       out_rect_x,
  input  logic [gcf_pkg::Y_W-1:0]       out_rect_y,
  input  logic [gcf_pkg::PIX_W-1:0]     out_pixels_01,
  input  logic [gcf_pkg::PIX_W-1:0]     out_pixels_23,
  input  logic [gcf_pkg::PIX_W-1:0]     out_pixels_45,
  input  logic [gcf_pkg::PIX_W-1:0]     out_pixels_67,
  input  logic                          out_last
);
  import gcf_pkg::*;

  // a stalled result stays offered
  `GCF_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid, "result dropped under stall")

  // a hit is always a single result without a load
  `GCF_ASSERT_IMPL(a_hit_single, out_valid && out_hit, out_last && !out_load_valid, "hit result malformed")

  // results without a load carry no rectangle and no pixels
  `GCF_ASSERT_IMPL(a_noload_zero, out_valid && !out_load_valid, out_last && (out_rect_x == '0) && (out_rect_y == '0) && (out_pixels_01 == '0) && (out_pixels_23 == '0) && (out_pixels_45 == '0) && (out_pixels_67 == '0), "non-load result not cleared")

  // a taken non-final load is followed at once by the next load of the same slot
  `GCF_ASSERT(a_load_burst, (out_valid && !out_stall && !out_last) |=> (out_valid && out_load_valid && (out_slot == $past(out_slot))), "load burst broken")

endmodule

bind glyph_cache_fifo_with_bit_expand_core gcf_checker u_gcf_checker (.*);
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
  import gcf_pkg::*;

  // watchdog limit on cycles with no transfer on either channel; the longest
  // correct gap is the receiver hold-off plus one full ring turn
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 300;
  localparam int IDLE_PCT       = 37;
  localparam int PHASE_ITEMS    = 85;

  // one request as driven on the input channel
  typedef struct {
    code_t                   code;
    logic                    present;
    logic [3:0][BYTES_W-1:0] bytes;
  } glyph_req_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              load_valid;
    logic [X_W-1:0]    rect_x;
    logic [Y_W-1:0]    rect_y;
    logic [PIX_W-1:0]  px01;
    logic [PIX_W-1:0]  px23;
    logic [PIX_W-1:0]  px45;
    logic [PIX_W-1:0]  px67;
    logic              last;
  } glyph_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                 in_valid;
  logic                 in_stall;
  logic [CODE_W-1:0]    in_char_code;
  logic                 in_glyph_present;
  logic [BYTES_W-1:0]   in_glyph_bytes_a;
  logic [BYTES_W-1:0]   in_glyph_bytes_b;
  logic [BYTES_W-1:0]   in_glyph_bytes_c;
  logic [BYTES_W-1:0]   in_glyph_bytes_d;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SLOT_W-1:0]    out_slot;
  logic                 out_hit;
  logic                 out_load_valid;
  logic [X_W-1:0]       out_rect_x;
  logic [Y_W-1:0]       out_rect_y;
  logic [PIX_W-1:0]     out_pixels_01;
  logic [PIX_W-1:0]     out_pixels_23;
  logic [PIX_W-1:0]     out_pixels_45;
  logic [PIX_W-1:0]     out_pixels_67;
  logic                 out_last;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  // our own copy of the cache table, the replace pointer and the bases
  code_t          model_codes [TABLE_ENTRIES];
  idx_t           model_victim;
  logic [X_W-1:0] model_base_x;
  logic [Y_W-1:0] model_base_y;

  glyph_result_t pending_results [$];
  code_t         seen_codes [$];
  int            err_cnt = 0;
  int            quiet_cycles = 0;

  // test-side controls read by the driver processes
  bit no_idle = 1'b0;
  bit rx_hold_req = 1'b0;
  // owned by the receiver process
  bit rx_hold_done = 1'b0;
  int rx_hold_left = 0;

  always #5 clk = ~clk;

  glyph_cache_fifo_with_bit_expand_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_glyph_present (in_glyph_present),
    .in_glyph_bytes_a (in_glyph_bytes_a),
    .in_glyph_bytes_b (in_glyph_bytes_b),
    .in_glyph_bytes_c (in_glyph_bytes_c),
    .in_glyph_bytes_d (in_glyph_bytes_d),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot         (out_slot),
    .out_hit          (out_hit),
    .out_load_valid   (out_load_valid),
    .out_rect_x       (out_rect_x),
    .out_rect_y       (out_rect_y),
    .out_pixels_01    (out_pixels_01),
    .out_pixels_23    (out_pixels_23),
    .out_pixels_45    (out_pixels_45),
    .out_pixels_67    (out_pixels_67),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_idx          (cfg_idx),
    .cfg_data         (cfg_data)
  );

  // 1bpp byte to eight 4-bit pixels, msb lands in the lowest nibble
  function automatic logic [31:0] expand_glyph_byte(input logic [7:0] b);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 8; j++) w[4*j] = b[7-j];
    return w;
  endfunction

  // search, claim on miss, and queue the results one request causes
  task automatic predict_glyph_lookup(input glyph_req_t r);
    glyph_result_t           res;
    int                      hit_at;
    idx_t                    slot;
    logic [BYTES_W-1:0]      src;
    logic [3:0][PIX_W-1:0]   px;
    hit_at = -1;
    // lowest matching slot wins
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (hit_at < 0 && model_codes[i] == r.code) hit_at = i;
    res = '0;
    res.last = 1'b1;
    if (hit_at >= 0) begin
      res.slot = SLOT_W'(hit_at);
      res.hit  = 1'b1;
      pending_results.push_back(res);
      return;
    end
    // miss: fifo replacement, pointer wraps after the last slot
    slot = model_victim;
    model_codes[slot] = r.code;
    model_victim = model_victim + 1'b1;
    res.slot = slot;
    if (!r.present) begin
      pending_results.push_back(res);
      return;
    end
    for (int k = 0; k < LOADS; k++) begin
      src = r.bytes[k];
      for (int m = 0; m < 4; m++)
        px[m] = {expand_glyph_byte(src[16*m+8 +: 8]), expand_glyph_byte(src[16*m +: 8])};
      res.load_valid = 1'b1;
      // rectangle wraps at the field widths
      res.rect_x = model_base_x + X_W'({slot[3:0], 2'b00});
      res.rect_y = model_base_y + Y_W'({slot[7:4], 4'b0000}) + Y_W'(4 * k);
      res.px01 = px[0];
      res.px23 = px[1];
      res.px45 = px[2];
      res.px67 = px[3];
      res.last = (k == LOADS - 1);
      pending_results.push_back(res);
    end
  endtask

  // offer one request from the falling edge, hold it until it is taken
  task automatic send_glyph_req(input glyph_req_t r);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_char_code     <= r.code;
    in_glyph_present <= r.present;
    in_glyph_bytes_a <= r.bytes[0];
    in_glyph_bytes_b <= r.bytes[1];
    in_glyph_bytes_c <= r.bytes[2];
    in_glyph_bytes_d <= r.bytes[3];
    do @(posedge clk); while (in_stall);
    predict_glyph_lookup(r);
    seen_codes.push_back(r.code);
    if (seen_codes.size() > 300) void'(seen_codes.pop_front());
  endtask

  // drop valid, then wait until every queued result has come back
  task automatic finish_phase();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    if (idx == CFG_BASE_X) model_base_x = data[X_W-1:0];
    else if (idx == CFG_BASE_Y) model_base_y = data[Y_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic glyph_req_t make_req(input code_t code, input logic present,
                                          input logic [BYTES_W-1:0] a,
                                          input logic [BYTES_W-1:0] b,
                                          input logic [BYTES_W-1:0] c,
                                          input logic [BYTES_W-1:0] d);
    glyph_req_t r;
    r.code     = code;
    r.present  = present;
    r.bytes[0] = a;
    r.bytes[1] = b;
    r.bytes[2] = c;
    r.bytes[3] = d;
    return r;
  endfunction

  // mostly fresh codes so the pointer wraps, some reuse for hits
  task automatic make_random_req(output glyph_req_t r);
    int pick;
    pick = $urandom_range(99);
    if (pick < 25 && seen_codes.size() != 0)
      r.code = seen_codes[$urandom_range(seen_codes.size() - 1)];
    else if (pick < 30)
      r.code = ($urandom_range(1) != 0) ? 16'hffff : 16'h0000;
    else
      r.code = code_t'($urandom_range(65535));
    r.present = ($urandom_range(99) < 70);
    for (int k = 0; k < LOADS; k++) r.bytes[k] = {$urandom, $urandom};
  endtask

  // code zero hits slot 0 while the table still holds its reset contents
  task automatic test_reset_table();
    send_glyph_req(make_req(16'h0000, 1'b1, '1, '1, '1, '1));
    finish_phase();
  endtask

  // misses with and without glyph data, hits, lowest-slot match, byte extremes
  task automatic test_miss_and_hit();
    write_reg(CFG_BASE_X, 10'd0);
    write_reg(CFG_BASE_Y, 10'd0);
    send_glyph_req(make_req(16'h0041, 1'b1, '1, '1, '1, '1));
    send_glyph_req(make_req(16'hffff, 1'b1, 64'haa55_aa55_aa55_aa55,
                            64'h55aa_55aa_55aa_55aa, 64'hf00f_0ff0_ff00_00ff,
                            64'h0102_0408_1020_4080));
    send_glyph_req(make_req(16'h1234, 1'b0, '1, '1, '1, '1));
    send_glyph_req(make_req(16'h0041, 1'b1, '0, '0, '0, '0));
    send_glyph_req(make_req(16'h1234, 1'b0, '0, '0, '0, '0));
    // slot 0 was replaced, so zero now matches the lowest untouched slot
    send_glyph_req(make_req(16'h0000, 1'b0, '0, '0, '0, '0));
    send_glyph_req(make_req(16'h8000, 1'b1, '0, '0, '0, '0));
    send_glyph_req(make_req(16'h0001, 1'b1, 64'h8040_2010_0804_0201,
                            64'h8000_0000_0000_0001, 64'h0000_0080_0100_0000,
                            64'hfe7f_fdbf_fbdf_f7ef));
    send_glyph_req(make_req(16'hffff, 1'b1, '1, '1, '1, '1));
    finish_phase();
  endtask

  // largest bases so the rectangle fields wrap; bit 9 of base_y data is dropped
  task automatic test_rect_wrap();
    glyph_req_t r;
    write_reg(CFG_BASE_X, 10'h3ff);
    write_reg(CFG_BASE_Y, 10'h3ff);
    for (int n = 0; n < 4; n++) begin
      r = make_req(code_t'(16'h7f00 + n), 1'b1, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      send_glyph_req(r);
    end
    finish_phase();
  endtask

  // receiver holds off while requests keep coming, the block must back up
  task automatic test_backpressure();
    glyph_req_t r;
    write_reg(CFG_BASE_X, 10'd100);
    write_reg(CFG_BASE_Y, 10'd200);
    rx_hold_req = 1'b1;
    for (int n = 0; n < 8; n++) begin
      make_random_req(r);
      send_glyph_req(r);
    end
    finish_phase();
  endtask

  // random requests under one base setting
  task automatic test_random_phase(input logic [CFG_W-1:0] bx, input logic [CFG_W-1:0] by,
                                   input bit steady);
    glyph_req_t r;
    write_reg(CFG_BASE_X, bx);
    write_reg(CFG_BASE_Y, by);
    no_idle = steady;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      make_random_req(r);
      send_glyph_req(r);
    end
    finish_phase();
    no_idle = 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request, none when steady
  always @(negedge clk) begin
    if (rx_hold_req && !rx_hold_done) begin
      rx_hold_done = 1'b1;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic cmp_field(input string name, input logic [63:0] exp_v,
                           input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t %s: expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // each taken result against the oldest expectation
  always @(posedge clk) begin
    glyph_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected result: expected none, got slot %0h", $time, out_slot);
      end else begin
        want = pending_results.pop_front();
        cmp_field("slot", want.slot, out_slot);
        cmp_field("hit", want.hit, out_hit);
        cmp_field("load_valid", want.load_valid, out_load_valid);
        cmp_field("rect_x", want.rect_x, out_rect_x);
        cmp_field("rect_y", want.rect_y, out_rect_y);
        cmp_field("pixels_01", want.px01, out_pixels_01);
        cmp_field("pixels_23", want.px23, out_pixels_23);
        cmp_field("pixels_45", want.px45, out_pixels_45);
        cmp_field("pixels_67", want.px67, out_pixels_67);
        cmp_field("last", want.last, out_last);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("glyph_cache_fifo_with_bit_expand_core: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_char_code     = '0;
    in_glyph_present = 1'b0;
    in_glyph_bytes_a = '0;
    in_glyph_bytes_b = '0;
    in_glyph_bytes_c = '0;
    in_glyph_bytes_d = '0;
    cfg_wr_en        = 1'b0;
    cfg_idx          = CFG_BASE_X;
    cfg_data         = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) model_codes[i] = '0;
    model_victim = '0;
    model_base_x = '0;
    model_base_y = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_table();
    test_miss_and_hit();
    test_rect_wrap();
    test_backpressure();
    test_random_phase(10'd0, 10'd0, 1'b0);
    test_random_phase(10'h3ff, 10'h1ff, 1'b0);
    // steady stretch: neither side idles
    test_random_phase(CFG_W'($urandom_range(1023)), CFG_W'($urandom_range(1023)), 1'b1);
    test_random_phase(CFG_W'($urandom_range(1023)), CFG_W'($urandom_range(511)), 1'b0);

    repeat (END_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      err_cnt++;
      $display("%0t leftover: expected 0 results waiting, got %0d", $time,
               pending_results.size());
    end
    if (err_cnt == 0) begin
      $display("glyph_cache_fifo_with_bit_expand_core: match");
    end else begin
      $display("glyph_cache_fifo_with_bit_expand_core: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
